// File: rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define TSRN_ASSERT(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

`define TSRN_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define TSRN_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TSRN_ASSERT(name, clk, rst_n, cond)
`define TSRN_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TSRN_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/tsrn_pkg.sv
`default_nettype none

package tsrn_pkg;

    localparam int DEPTH  = 1024;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int NCELL  = CW + 1;
    localparam int TW     = 63;
    localparam int OFF_W  = 10;
    localparam int FILL_W = 11;
    localparam int POL_W  = 2;
    localparam int STAT_W = 2;

    localparam logic [CW:0]   DEPTH_X   = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [POL_W-1:0] POL_CLOSEST = 2'd0;
    localparam logic [POL_W-1:0] POL_PREV    = 2'd1;
    localparam logic [POL_W-1:0] POL_NEXT    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_MATCH = 2'd2;

    typedef struct packed {
        logic             op;
        logic [TW-1:0]    time_value;
        logic [TW-1:0]    end_time;
        logic [POL_W-1:0] start_policy;
        logic [POL_W-1:0] end_policy;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  start_offset;
        logic [TW-1:0]     start_match_time;
        logic [OFF_W-1:0]  end_offset;
        logic [TW-1:0]     end_match_time;
        logic [FILL_W-1:0] fill_count;
    } t_out_item;

    // search token handed from cell to cell
    typedef struct packed {
        logic          valid;
        logic          tag;
        logic [CW-1:0] pos;
        logic [CW-1:0] cand;
        logic          probe;
        logic [TW-1:0] target;
    } t_tok;

    typedef struct packed {
        logic          valid;
        logic          tag;
        logic [AW-1:0] addr;
    } t_probe;

    function automatic logic [AW-1:0] wrap_addr(input logic [CW:0] sum);
        logic [CW:0] adj;
        adj = (sum >= DEPTH_X) ? (sum - DEPTH_X) : sum;
        return adj[AW-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/tsrn_cell.sv
`default_nettype none

module tsrn_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [tsrn_pkg::CW-1:0] i_weight,
    input  wire logic [tsrn_pkg::CW-1:0] i_count,
    input  wire logic [tsrn_pkg::AW-1:0] i_oldest,
    input  wire logic [tsrn_pkg::TW-1:0] i_rdata_a,
    input  wire logic [tsrn_pkg::TW-1:0] i_rdata_b,
    input  wire tsrn_pkg::t_tok        i_tok,
    output tsrn_pkg::t_tok             o_tok,
    output tsrn_pkg::t_probe           o_probe
);

    tsrn_pkg::t_tok                r_tok;
    tsrn_pkg::t_tok                n_tok;
    logic [tsrn_pkg::TW-1:0]       rd;
    logic                          take;
    logic [tsrn_pkg::CW-1:0]       pos_now;
    logic [tsrn_pkg::CW:0]         cand_sum;
    logic                          probe_n;

    // resolve the probe issued one cell earlier, then issue this cell's probe
    always_comb begin
        rd       = i_tok.tag ? i_rdata_b : i_rdata_a;
        take     = i_tok.probe && (rd < i_tok.target);
        pos_now  = take ? i_tok.cand : i_tok.pos;
        cand_sum = (tsrn_pkg::CW + 1)'(pos_now) + (tsrn_pkg::CW + 1)'(i_weight);
        probe_n  = (i_weight != '0) && (cand_sum <= (tsrn_pkg::CW + 1)'(i_count));

        n_tok        = i_tok;
        n_tok.pos    = pos_now;
        n_tok.cand   = cand_sum[tsrn_pkg::CW-1:0];
        n_tok.probe  = probe_n;

        o_probe.valid = i_tok.valid && probe_n;
        o_probe.tag   = i_tok.tag;
        o_probe.addr  = tsrn_pkg::wrap_addr((tsrn_pkg::CW + 1)'(i_oldest) + cand_sum
                                            - (tsrn_pkg::CW + 1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: rtl/tsrn_chain.sv
`default_nettype none

module tsrn_chain (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [tsrn_pkg::CW-1:0] i_count,
    input  wire logic [tsrn_pkg::AW-1:0] i_oldest,
    input  wire logic [tsrn_pkg::TW-1:0] i_rdata_a,
    input  wire logic [tsrn_pkg::TW-1:0] i_rdata_b,
    input  wire tsrn_pkg::t_tok          i_tok,
    output tsrn_pkg::t_tok               o_tok,
    output logic [tsrn_pkg::AW-1:0]      o_addr_a,
    output logic [tsrn_pkg::AW-1:0]      o_addr_b,
    output logic                         o_busy
);

    tsrn_pkg::t_tok   toks   [0:tsrn_pkg::NCELL];
    tsrn_pkg::t_probe probes [0:tsrn_pkg::NCELL-1];

    assign toks[0] = i_tok;

    for (genvar k = 0; k < tsrn_pkg::NCELL; k++) begin : g_cell
        // halving step weights, last cell only resolves
        localparam int unsigned WEIGHT_INT = (32'd1 << tsrn_pkg::CW) >> (k + 1);
        localparam logic [tsrn_pkg::CW-1:0] WEIGHT = tsrn_pkg::CW'(WEIGHT_INT);

        tsrn_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_weight  (WEIGHT),
            .i_count   (i_count),
            .i_oldest  (i_oldest),
            .i_rdata_a (i_rdata_a),
            .i_rdata_b (i_rdata_b),
            .i_tok     (toks[k]),
            .o_tok     (toks[k+1]),
            .o_probe   (probes[k])
        );
    end

    always_comb begin
        o_addr_a = '0;
        o_addr_b = '0;
        o_busy   = 1'b0;
        for (int k = 0; k < tsrn_pkg::NCELL; k++) begin
            if (probes[k].valid) begin
                if (probes[k].tag) begin
                    o_addr_b = o_addr_b | probes[k].addr;
                end else begin
                    o_addr_a = o_addr_a | probes[k].addr;
                end
            end
            o_busy = o_busy | toks[k+1].valid;
        end
    end

    assign o_tok = toks[tsrn_pkg::NCELL];

endmodule

`default_nettype wire

// File: rtl/timestamp_ring_nearest_match.sv
// Sorted timestamp ring with nearest-match range queries.
// Input channel i_in_valid / o_in_ready carries one transaction per item:
// op add appends time_value, op query matches time_value and end_time under
// their own policies. Output channel o_out_valid / i_out_ready returns exactly
// one result transaction per input transaction, in order.
// One item is worked on at a time. An add reads the newest sample and rejects
// a time_value not above it; a query runs its start and end searches through
// a chain of CW + 1 search cells, one step per cell, staggered on the two read
// ports of the timestamp memory, followed by neighbor reads and the nearest pick.
// A new item can be accepted again once the result is registered.
// The result sits in an output register; while the receiver stalls the block
// finishes the next item up to its result and holds there until the output
// register frees. Reset clears the entry count and the oldest pointer; the
// memory itself is not cleared and needs no pass after reset.
`default_nettype none

`include "assert_macros.svh"

module timestamp_ring_nearest_match (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tsrn_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tsrn_pkg::t_out_item      o_out_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD_RD  = 4'd1;
    localparam logic [3:0] S_ADD_CMP = 4'd2;
    localparam logic [3:0] S_LAUNCH  = 4'd3;
    localparam logic [3:0] S_SEARCH  = 4'd4;
    localparam logic [3:0] S_RD_NEXT = 4'd5;
    localparam logic [3:0] S_RD_PREV = 4'd6;
    localparam logic [3:0] S_DIFF    = 4'd7;
    localparam logic [3:0] S_DECIDE  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    typedef struct packed {
        logic                    ok;
        logic                    use_next;
        logic [tsrn_pkg::CW-1:0] pos;
    } t_match;

    logic [3:0]                    r_state;
    logic [3:0]                    n_state;
    logic [tsrn_pkg::CW-1:0]       r_count;
    logic [tsrn_pkg::CW-1:0]       n_count;
    logic [tsrn_pkg::AW-1:0]       r_oldest;
    logic [tsrn_pkg::AW-1:0]       n_oldest;
    tsrn_pkg::t_tok                r_launch;
    tsrn_pkg::t_tok                n_launch;
    logic                          r_out_valid;
    logic                          n_out_valid;
    tsrn_pkg::t_in_item            r_in;
    tsrn_pkg::t_out_item           r_res;
    tsrn_pkg::t_out_item           r_out;
    logic [tsrn_pkg::CW-1:0]       r_lb_s;
    logic [tsrn_pkg::CW-1:0]       r_lb_e;
    logic [tsrn_pkg::TW-1:0]       r_s_next;
    logic [tsrn_pkg::TW-1:0]       r_e_next;
    logic [tsrn_pkg::TW-1:0]       r_s_prev;
    logic [tsrn_pkg::TW-1:0]       r_e_prev;
    logic [tsrn_pkg::TW-1:0]       r_s_dprev;
    logic [tsrn_pkg::TW-1:0]       r_s_dnext;
    logic [tsrn_pkg::TW-1:0]       r_e_dprev;
    logic [tsrn_pkg::TW-1:0]       r_e_dnext;
    logic                          r_s_eq;
    logic                          r_e_eq;
    logic [tsrn_pkg::TW-1:0]       r_mem [0:tsrn_pkg::DEPTH-1];
    logic [tsrn_pkg::TW-1:0]       r_rdata_a;
    logic [tsrn_pkg::TW-1:0]       r_rdata_b;

    logic                          in_fire;
    logic                          load_out;
    logic                          add_reject;
    logic                          mem_we;
    logic [tsrn_pkg::AW-1:0]       wr_addr;
    logic [tsrn_pkg::AW-1:0]       newest_addr;
    logic [tsrn_pkg::AW-1:0]       s_next_addr;
    logic [tsrn_pkg::AW-1:0]       e_next_addr;
    logic [tsrn_pkg::AW-1:0]       s_prev_addr;
    logic [tsrn_pkg::AW-1:0]       e_prev_addr;
    logic [tsrn_pkg::AW-1:0]       rd_addr_a;
    logic [tsrn_pkg::AW-1:0]       rd_addr_b;
    logic [tsrn_pkg::AW-1:0]       chain_addr_a;
    logic [tsrn_pkg::AW-1:0]       chain_addr_b;
    logic                          chain_busy;
    tsrn_pkg::t_tok                done_tok;
    t_match                        ms;
    t_match                        me;
    tsrn_pkg::t_out_item           query_res;

    function automatic t_match match_side(
        input logic [tsrn_pkg::CW-1:0]    lb,
        input logic [tsrn_pkg::CW-1:0]    n,
        input logic                       eq_raw,
        input logic                       lt,
        input logic [tsrn_pkg::POL_W-1:0] policy
    );
        logic   has_next;
        logic   eq;
        logic   has_prev;
        t_match prev_m;
        t_match next_m;
        t_match m;
        has_next = lb < n;
        eq       = has_next && eq_raw;
        has_prev = eq || (lb != '0);
        // an exact hit is its own previous match
        prev_m.ok       = has_prev;
        prev_m.use_next = eq;
        prev_m.pos      = eq ? lb : (lb - tsrn_pkg::CW'(1));
        next_m.ok       = has_next;
        next_m.use_next = 1'b1;
        next_m.pos      = lb;
        m = '0;
        unique case (policy)
            tsrn_pkg::POL_PREV: begin
                m = prev_m;
            end
            tsrn_pkg::POL_NEXT: begin
                m = next_m;
            end
            tsrn_pkg::POL_CLOSEST: begin
                if (!has_prev) begin
                    m = next_m;
                end else if (!has_next) begin
                    m = prev_m;
                end else if (lt && !eq) begin
                    m = prev_m;
                end else begin
                    m = next_m;
                end
            end
            default: begin
                m = '0;
            end
        endcase
        return m;
    endfunction

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign load_out   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign add_reject = (r_count != '0) && (r_in.time_value <= r_rdata_a);

    // ring addresses
    always_comb begin
        wr_addr     = tsrn_pkg::wrap_addr((tsrn_pkg::CW + 1)'(r_oldest)
                                          + (tsrn_pkg::CW + 1)'(r_count));
        newest_addr = tsrn_pkg::wrap_addr((tsrn_pkg::CW + 1)'(r_oldest)
                          + (tsrn_pkg::CW + 1)'((r_count == '0) ? r_count
                                                : (r_count - tsrn_pkg::CW'(1))));
        s_next_addr = tsrn_pkg::wrap_addr((tsrn_pkg::CW + 1)'(r_oldest)
                                          + (tsrn_pkg::CW + 1)'(r_lb_s));
        e_next_addr = tsrn_pkg::wrap_addr((tsrn_pkg::CW + 1)'(r_oldest)
                                          + (tsrn_pkg::CW + 1)'(r_lb_e));
        s_prev_addr = tsrn_pkg::wrap_addr((tsrn_pkg::CW + 1)'(r_oldest)
                          + (tsrn_pkg::CW + 1)'((r_lb_s == '0) ? r_lb_s
                                                : (r_lb_s - tsrn_pkg::CW'(1))));
        e_prev_addr = tsrn_pkg::wrap_addr((tsrn_pkg::CW + 1)'(r_oldest)
                          + (tsrn_pkg::CW + 1)'((r_lb_e == '0) ? r_lb_e
                                                : (r_lb_e - tsrn_pkg::CW'(1))));
    end

    always_comb begin
        rd_addr_a = chain_addr_a;
        rd_addr_b = chain_addr_b;
        case (r_state)
            S_ADD_RD: begin
                rd_addr_a = newest_addr;
            end
            S_RD_NEXT: begin
                rd_addr_a = s_next_addr;
                rd_addr_b = e_next_addr;
            end
            S_RD_PREV: begin
                rd_addr_a = s_prev_addr;
                rd_addr_b = e_prev_addr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= r_in.time_value;
        end
        r_rdata_a <= r_mem[rd_addr_a];
        r_rdata_b <= r_mem[rd_addr_b];
    end

    tsrn_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_count   (r_count),
        .i_oldest  (r_oldest),
        .i_rdata_a (r_rdata_a),
        .i_rdata_b (r_rdata_b),
        .i_tok     (r_launch),
        .o_tok     (done_tok),
        .o_addr_a  (chain_addr_a),
        .o_addr_b  (chain_addr_b),
        .o_busy    (chain_busy)
    );

    // control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_oldest    = r_oldest;
        n_launch    = r_launch;
        n_launch.valid = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        mem_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.op == tsrn_pkg::OP_ADD) begin
                        n_state = S_ADD_RD;
                    end else begin
                        n_state  = S_LAUNCH;
                        n_launch = '{valid: 1'b1, tag: 1'b0, pos: '0, cand: '0,
                                     probe: 1'b0, target: i_in_data.time_value};
                    end
                end
            end
            S_ADD_RD: begin
                n_state = S_ADD_CMP;
            end
            S_ADD_CMP: begin
                if (!add_reject) begin
                    mem_we = 1'b1;
                    if (r_count == tsrn_pkg::DEPTH_CNT) begin
                        n_oldest = tsrn_pkg::wrap_addr((tsrn_pkg::CW + 1)'(r_oldest)
                                                       + (tsrn_pkg::CW + 1)'(1));
                    end else begin
                        n_count = r_count + tsrn_pkg::CW'(1);
                    end
                end
                n_state = S_DONE;
            end
            S_LAUNCH: begin
                n_launch = '{valid: 1'b1, tag: 1'b1, pos: '0, cand: '0,
                             probe: 1'b0, target: r_in.end_time};
                n_state  = S_SEARCH;
            end
            S_SEARCH: begin
                if (done_tok.valid && done_tok.tag) begin
                    n_state = S_RD_NEXT;
                end
            end
            S_RD_NEXT: begin
                n_state = S_RD_PREV;
            end
            S_RD_PREV: begin
                n_state = S_DIFF;
            end
            S_DIFF: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_oldest    <= n_oldest;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch <= '0;
        end else begin
            r_launch <= n_launch;
        end
    end

    // nearest pick for both sides
    always_comb begin
        ms = match_side(r_lb_s, r_count, r_s_eq, r_s_dprev < r_s_dnext,
                        r_in.start_policy);
        me = match_side(r_lb_e, r_count, r_e_eq, r_e_dprev < r_e_dnext,
                        r_in.end_policy);
        query_res = '0;
        query_res.fill_count = tsrn_pkg::FILL_W'(r_count);
        if (ms.ok && me.ok) begin
            query_res.status           = tsrn_pkg::ST_OK;
            query_res.start_offset     = tsrn_pkg::OFF_W'(ms.pos);
            query_res.start_match_time = ms.use_next ? r_s_next : r_s_prev;
            query_res.end_offset       = tsrn_pkg::OFF_W'(me.pos);
            query_res.end_match_time   = me.use_next ? r_e_next : r_e_prev;
        end else begin
            query_res.status = tsrn_pkg::ST_NO_MATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
        case (r_state)
            S_ADD_CMP: begin
                r_res <= '{status: add_reject ? tsrn_pkg::ST_REJECT : tsrn_pkg::ST_OK,
                           start_offset: '0, start_match_time: '0,
                           end_offset: '0, end_match_time: '0,
                           fill_count: tsrn_pkg::FILL_W'(n_count)};
            end
            S_SEARCH: begin
                if (done_tok.valid) begin
                    if (done_tok.tag) begin
                        r_lb_e <= done_tok.pos;
                    end else begin
                        r_lb_s <= done_tok.pos;
                    end
                end
            end
            S_RD_PREV: begin
                r_s_next <= r_rdata_a;
                r_e_next <= r_rdata_b;
            end
            S_DIFF: begin
                r_s_prev  <= r_rdata_a;
                r_e_prev  <= r_rdata_b;
                r_s_dprev <= r_in.time_value - r_rdata_a;
                r_e_dprev <= r_in.end_time - r_rdata_b;
                r_s_dnext <= r_s_next - r_in.time_value;
                r_e_dnext <= r_e_next - r_in.end_time;
                r_s_eq    <= (r_s_next == r_in.time_value);
                r_e_eq    <= (r_e_next == r_in.end_time);
            end
            S_DECIDE: begin
                r_res <= query_res;
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TSRN_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= tsrn_pkg::DEPTH_CNT)
    `TSRN_ASSERT_IMPL(a_idle_chain_empty, i_clk, i_rst_n, r_state == S_IDLE, !chain_busy && !r_launch.valid)
    `TSRN_ASSERT_IMPL(a_ok_offsets, i_clk, i_rst_n, o_out_valid && (o_out_data.status == tsrn_pkg::ST_OK), (o_out_data.start_offset < o_out_data.fill_count) && (o_out_data.end_offset < o_out_data.fill_count))
    `TSRN_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n, load_out, o_out_valid && (r_state == S_IDLE))

endmodule

`default_nettype wire

// File: bench/tb_timestamp_ring_nearest_match.sv
module tb_timestamp_ring_nearest_match;
    import tsrn_pkg::*;

    localparam logic [TW-1:0]    TIME_MAX     = {TW{1'b1}};
    localparam logic [POL_W-1:0] POL_UNDEF    = 2'd3;
    localparam int               RANDOM_ITEMS = 1680;
    localparam int               HOLD_AT      = 600;
    localparam int               HOLD_CYCLES  = 400;
    localparam int               PAUSE_AT     = 1200;
    localparam int               DRAIN_CYCLES = 40;
    localparam int               LIMIT_TIME   = 3000000;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    // ring copy kept by the bench
    logic [TW-1:0] ring_mem [DEPTH];
    int unsigned   ring_head = 0;
    int unsigned   ring_fill = 0;

    t_out_item   pending_answers [$];
    t_stim_row   stim_rows [$];
    bit          hold_request  = 1'b0;
    int unsigned error_count   = 0;
    int unsigned answers_seen  = 0;
    int unsigned n_items       = 0;
    int unsigned n_adds        = 0;
    int unsigned n_rejects     = 0;
    int unsigned n_queries     = 0;
    int unsigned n_no_match    = 0;
    int unsigned n_overwrites  = 0;

    timestamp_ring_nearest_match uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [TW-1:0] ring_at(int unsigned pos);
        return ring_mem[(ring_head + pos) % DEPTH];
    endfunction

    function automatic int unsigned entries_below(logic [TW-1:0] t, bit inclusive);
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   mid;
        logic [TW-1:0] v;
        lo = 0;
        hi = ring_fill;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            v = ring_at(mid);
            if (inclusive ? (v <= t) : (v < t)) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic bit nearest_pos(logic [TW-1:0] t, logic [POL_W-1:0] pol,
                                       output int unsigned pos);
        int unsigned up;
        int unsigned lb;
        bit          has_prev;
        bit          has_next;
        bit          found;
        up = entries_below(t, 1'b1);
        lb = entries_below(t, 1'b0);
        has_prev = up > 0;
        has_next = lb < ring_fill;
        pos = 0;
        found = 1'b0;
        case (pol)
            POL_PREV: begin
                found = has_prev;
                if (has_prev) pos = up - 1;
            end
            POL_NEXT: begin
                found = has_next;
                pos = lb;
            end
            POL_CLOSEST: begin
                found = has_prev || has_next;
                if (!has_prev) begin
                    pos = lb;
                end else if (!has_next) begin
                    pos = up - 1;
                end else if (t - ring_at(up - 1) < ring_at(lb) - t) begin
                    pos = up - 1;
                end else begin
                    pos = lb;
                end
            end
            default: found = 1'b0;
        endcase
        return found;
    endfunction

    function automatic t_out_item ring_answer(t_in_item it);
        t_out_item   res;
        int unsigned spos;
        int unsigned epos;
        bit          s_ok;
        bit          e_ok;
        res = '0;
        res.status = ST_OK;
        if (it.op == OP_ADD) begin
            if (ring_fill > 0 && it.time_value <= ring_at(ring_fill - 1)) begin
                res.status = ST_REJECT;
            end else begin
                ring_mem[(ring_head + ring_fill) % DEPTH] = it.time_value;
                if (ring_fill < DEPTH) begin
                    ring_fill++;
                end else begin
                    ring_head = (ring_head + 1) % DEPTH;
                    n_overwrites++;
                end
            end
        end else begin
            s_ok = nearest_pos(it.time_value, it.start_policy, spos);
            e_ok = nearest_pos(it.end_time, it.end_policy, epos);
            if (s_ok && e_ok) begin
                res.start_offset     = OFF_W'(spos);
                res.start_match_time = ring_at(spos);
                res.end_offset       = OFF_W'(epos);
                res.end_match_time   = ring_at(epos);
            end else begin
                res.status = ST_NO_MATCH;
            end
        end
        res.fill_count = FILL_W'(ring_fill);
        return res;
    endfunction

    function automatic t_in_item make_item(logic op, logic [TW-1:0] tv, logic [TW-1:0] te,
                                           logic [POL_W-1:0] sp, logic [POL_W-1:0] ep);
        t_in_item it;
        it.op           = op;
        it.time_value   = tv;
        it.end_time     = te;
        it.start_policy = sp;
        it.end_policy   = ep;
        return it;
    endfunction

    function automatic t_out_item make_result(logic [STAT_W-1:0] st, logic [OFF_W-1:0] so,
                                              logic [TW-1:0] stt, logic [OFF_W-1:0] eo,
                                              logic [TW-1:0] et, logic [FILL_W-1:0] fill);
        t_out_item res;
        res.status           = st;
        res.start_offset     = so;
        res.start_match_time = stt;
        res.end_offset       = eo;
        res.end_match_time   = et;
        res.fill_count       = fill;
        return res;
    endfunction

    function automatic t_stim_row typed_row(t_in_item it, t_out_item want);
        t_stim_row row;
        row.item  = it;
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic t_stim_row model_row(t_in_item it);
        t_stim_row row;
        row.item  = it;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic logic [TW-1:0] rand_time();
        return TW'({$urandom, $urandom});
    endfunction

    function automatic logic [POL_W-1:0] random_policy();
        if ($urandom_range(0, 99) < 5) return POL_UNDEF;
        return POL_W'($urandom_range(0, 2));
    endfunction

    // query time aimed at, between or away from stored samples
    function automatic logic [TW-1:0] aimed_time();
        int unsigned   pick;
        int unsigned   j;
        int            d;
        logic [TW-1:0] v;
        logic [TW-1:0] b;
        pick = $urandom_range(0, 99);
        j = $urandom_range(0, ring_fill - 1);
        v = ring_at(j);
        if (pick < 60) begin
            d = int'($urandom_range(0, 6)) - 3;
            if (d >= 0) begin
                v = v + TW'(d);
            end else if (v >= TW'(-d)) begin
                v = v - TW'(-d);
            end
        end else if (pick < 75) begin
            if (j + 1 < ring_fill) begin
                b = ring_at(j + 1);
                v = v + (b - v) / 2;
            end
        end else if (pick < 90) begin
            v = rand_time();
        end else begin
            case ($urandom_range(0, 2))
                0: v = '0;
                1: v = TIME_MAX;
                default: v = ring_at(ring_fill - 1) + TW'($urandom_range(1, 1000));
            endcase
        end
        return v;
    endfunction

    function automatic t_in_item random_item();
        t_in_item      it;
        logic [TW-1:0] newest;
        logic [TW-1:0] step;
        int unsigned   w;
        it.op           = ($urandom_range(0, 99) < 78) ? OP_ADD : OP_QUERY;
        it.end_time     = rand_time();
        it.start_policy = random_policy();
        it.end_policy   = random_policy();
        newest = ring_at(ring_fill - 1);
        if (it.op == OP_ADD) begin
            if ($urandom_range(0, 99) < 8) begin
                case ($urandom_range(0, 2))
                    0: it.time_value = newest;
                    1: it.time_value = newest - TW'($urandom_range(1, 3));
                    default: it.time_value = rand_time() % (newest + 1);
                endcase
            end else begin
                w = $urandom_range(1, 50);
                step = (rand_time() & ((TW'(1) << w) - 1)) + 1;
                it.time_value = newest + step;
            end
        end else begin
            it.time_value = aimed_time();
            it.end_time   = aimed_time();
        end
        return it;
    endfunction

    function automatic int unsigned sender_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= 100) begin
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     answers_seen, what, got, want);
        end
    endtask

    task automatic check_answer(t_out_item got);
        t_out_item want;
        answers_seen++;
        if (pending_answers.size() == 0) begin
            report_mismatch("transaction with nothing pending", got.status, '0);
        end else begin
            want = pending_answers.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.start_offset !== want.start_offset)
                report_mismatch("start_offset", got.start_offset, want.start_offset);
            if (got.start_match_time !== want.start_match_time)
                report_mismatch("start_match_time", got.start_match_time,
                                want.start_match_time);
            if (got.end_offset !== want.end_offset)
                report_mismatch("end_offset", got.end_offset, want.end_offset);
            if (got.end_match_time !== want.end_match_time)
                report_mismatch("end_match_time", got.end_match_time, want.end_match_time);
            if (got.fill_count !== want.fill_count)
                report_mismatch("fill_count", got.fill_count, want.fill_count);
        end
    endtask

    task automatic send_item(t_in_item it, bit typed, t_out_item typed_want);
        t_out_item want;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        want = ring_answer(it);
        n_items++;
        if (it.op == OP_ADD) begin
            n_adds++;
            if (want.status == ST_REJECT) n_rejects++;
        end else begin
            n_queries++;
            if (want.status == ST_NO_MATCH) n_no_match++;
        end
        pending_answers.push_back(typed ? typed_want : want);
    endtask

    task automatic idle_cycles(int unsigned n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_answers();
        idle_cycles(1);
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) check_answer(o_out_data);
    end

    // receiver side: bursts, short and long stalls, one long hold-off
    initial begin
        int unsigned n;
        int unsigned pick;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                i_out_ready <= 1'b1;
                if (pick < 20) begin
                    n = $urandom_range(30, 150);
                    repeat (n) @(posedge i_clk);
                end else begin
                    n = $urandom_range(1, 6);
                    repeat (n) @(posedge i_clk);
                    i_out_ready <= 1'b0;
                    n = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                     : $urandom_range(15, 60);
                    repeat (n) @(posedge i_clk);
                end
            end
        end
    end

    initial begin
        #(LIMIT_TIME);
        $display("timeout with %0d transactions pending", pending_answers.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int unsigned i;
        // empty store, then samples 0, 100, 200
        stim_rows.push_back(typed_row(make_item(OP_QUERY, '0, '0, POL_CLOSEST, POL_CLOSEST),
                            make_result(ST_NO_MATCH, '0, '0, '0, '0, 11'd0)));
        stim_rows.push_back(typed_row(make_item(OP_QUERY, TIME_MAX, TIME_MAX, POL_PREV,
                            POL_NEXT), make_result(ST_NO_MATCH, '0, '0, '0, '0, 11'd0)));
        stim_rows.push_back(typed_row(make_item(OP_ADD, '0, TIME_MAX, POL_UNDEF, POL_UNDEF),
                            make_result(ST_OK, '0, '0, '0, '0, 11'd1)));
        stim_rows.push_back(typed_row(make_item(OP_ADD, '0, '0, POL_CLOSEST, POL_CLOSEST),
                            make_result(ST_REJECT, '0, '0, '0, '0, 11'd1)));
        stim_rows.push_back(typed_row(make_item(OP_ADD, 63'd100, '0, POL_PREV, POL_NEXT),
                            make_result(ST_OK, '0, '0, '0, '0, 11'd2)));
        stim_rows.push_back(typed_row(make_item(OP_ADD, 63'd50, TIME_MAX, POL_NEXT, POL_PREV),
                            make_result(ST_REJECT, '0, '0, '0, '0, 11'd2)));
        stim_rows.push_back(typed_row(make_item(OP_ADD, 63'd200, '0, POL_CLOSEST, POL_CLOSEST),
                            make_result(ST_OK, '0, '0, '0, '0, 11'd3)));
        stim_rows.push_back(typed_row(make_item(OP_QUERY, '0, 63'd200, POL_PREV, POL_NEXT),
                            make_result(ST_OK, 10'd0, 63'd0, 10'd2, 63'd200, 11'd3)));
        stim_rows.push_back(model_row(make_item(OP_QUERY, 63'd150, 63'd149, POL_CLOSEST,
                            POL_CLOSEST)));
        stim_rows.push_back(model_row(make_item(OP_QUERY, 63'd50, 63'd51, POL_CLOSEST,
                            POL_PREV)));
        stim_rows.push_back(model_row(make_item(OP_QUERY, 63'd99, 63'd101, POL_NEXT,
                            POL_PREV)));
        stim_rows.push_back(typed_row(make_item(OP_QUERY, 63'd250, '0, POL_NEXT, POL_CLOSEST),
                            make_result(ST_NO_MATCH, '0, '0, '0, '0, 11'd3)));
        stim_rows.push_back(typed_row(make_item(OP_QUERY, 63'd100, 63'd201, POL_CLOSEST,
                            POL_NEXT), make_result(ST_NO_MATCH, '0, '0, '0, '0, 11'd3)));
        stim_rows.push_back(model_row(make_item(OP_QUERY, TIME_MAX, '0, POL_CLOSEST,
                            POL_CLOSEST)));
        stim_rows.push_back(typed_row(make_item(OP_QUERY, 63'd10, 63'd10, POL_UNDEF,
                            POL_CLOSEST), make_result(ST_NO_MATCH, '0, '0, '0, '0, 11'd3)));
        stim_rows.push_back(typed_row(make_item(OP_QUERY, 63'd10, 63'd10, POL_CLOSEST,
                            POL_UNDEF), make_result(ST_NO_MATCH, '0, '0, '0, '0, 11'd3)));
        stim_rows.push_back(model_row(make_item(OP_QUERY, '0, TIME_MAX, POL_PREV, POL_PREV)));
        stim_rows.push_back(model_row(make_item(OP_QUERY, 63'd300, 63'd300, POL_PREV,
                            POL_CLOSEST)));
        stim_rows.push_back(model_row(make_item(OP_QUERY, '0, '0, POL_NEXT, POL_NEXT)));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k]) begin
            send_item(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].want);
            idle_cycles(sender_gap());
        end
        wait_all_answers();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_AT) hold_request = 1'b1;
            if (i == PAUSE_AT) wait_all_answers();
            send_item(random_item(), 1'b0, '0);
            if (!hold_request && (i / 100) % 4 != 1) idle_cycles(sender_gap());
        end

        // top of the time range, then a repeat of it
        send_item(make_item(OP_ADD, TIME_MAX, '0, POL_CLOSEST, POL_CLOSEST), 1'b0, '0);
        send_item(make_item(OP_QUERY, TIME_MAX, TIME_MAX, POL_PREV, POL_NEXT), 1'b0, '0);
        send_item(make_item(OP_ADD, TIME_MAX, TIME_MAX, POL_NEXT, POL_PREV), 1'b0, '0);
        send_item(make_item(OP_QUERY, '0, TIME_MAX, POL_NEXT, POL_CLOSEST), 1'b0, '0);
        idle_cycles(1);

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("ran %0d transactions: %0d adds with %0d rejected, %0d range queries"
                 , n_items, n_adds, n_rejects, n_queries);
        $display("%0d queries without match, %0d oldest samples overwritten, %0d mismatches",
                 n_no_match, n_overwrites, error_count);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
